// ===== src/tosr_pkg.sv =====
// ----------------------------------------------------------------------------
// Takeoff sequencer package
// Shared types, codes and constants of the takeoff sequencer with ramp.
// ----------------------------------------------------------------------------
`default_nettype none

package tosr_pkg;

  localparam int unsigned DIV_W      = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned VZ_W       = 21;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPOOL = 2'd2;

  localparam logic [15:0] GAIN_RESET  = 16'd4000;
  localparam logic [23:0] RAMP_RESET  = 24'd3000000;
  localparam logic [23:0] SPOOL_RESET = 24'd1500000;
  localparam logic [15:0] GAIN_FLOOR  = 16'd10;

  // Gravity in micrometres per second squared.
  localparam logic [DIV_W-1:0] GRAV_UM_S2 = 24'd9806650;

  localparam logic [16:0] Q16_ONE = 17'h10000;

  localparam logic signed [VZ_W-1:0] START_VZ_RESET = -21'sd2451;
  localparam logic signed [22:0]     VZ_MAX         = 23'sd1000000;

  typedef enum logic [2:0] {
    PH_DISARMED = 3'd0,
    PH_SPOOLUP  = 3'd1,
    PH_READY    = 3'd2,
    PH_RAMPUP   = 3'd3,
    PH_FLIGHT   = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GDIV,
    ST_PHASE,
    ST_STEP,
    ST_DIV,
    ST_MUL,
    ST_FIN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] rem_init;
    logic [DIV_W-1:0] num_init;
    logic [DIV_W-1:0] divisor;
    logic [4:0]       last;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;

  function automatic logic signed [VZ_W-1:0] sat_vz(input logic signed [22:0] v);
    logic signed [VZ_W-1:0] r;
    if (v > VZ_MAX) begin
      r = VZ_MAX[VZ_W-1:0];
    end else if (v < -VZ_MAX) begin
      r = VZ_W'(-VZ_MAX);
    end else begin
      r = v[VZ_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/tosr_in_if.sv =====
// ----------------------------------------------------------------------------
// Takeoff sequencer input channel
// Valid/ready channel carrying one control tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface tosr_in_if;
  logic               valid;
  logic               ready;
  logic               armed;
  logic               landed;
  logic               takeoff_req;
  logic               direct_flight;
  logic [31:0]        now_us;
  logic [19:0]        dt_us;
  logic signed [15:0] desired_vz_mm_s;

  modport source (
    output valid, armed, landed, takeoff_req, direct_flight, now_us, dt_us,
           desired_vz_mm_s,
    input  ready
  );

  modport sink (
    input  valid, armed, landed, takeoff_req, direct_flight, now_us, dt_us,
           desired_vz_mm_s,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/tosr_out_if.sv =====
// ----------------------------------------------------------------------------
// Takeoff sequencer output channel
// Valid/ready channel carrying the velocity limit and the phase.
// ----------------------------------------------------------------------------
`default_nettype none

interface tosr_out_if;
  logic               valid;
  logic               ready;
  logic signed [20:0] vz_limit_mm_s;
  logic [2:0]         phase;

  modport source (
    output valid, vz_limit_mm_s, phase,
    input  ready
  );

  modport sink (
    input  valid, vz_limit_mm_s, phase,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/tosr_sdiv.sv =====
// ----------------------------------------------------------------------------
// Serial restoring divider
// Produces one quotient bit per cycle, numerator bits shifted in MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module tosr_sdiv import tosr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] num_q, num_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0] dvs_q, dvs_d;
  logic [4:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DIV_W:0]   shifted;
  logic [DIV_W+1:0] trial;

  assign shifted = {rem_q, num_q[DIV_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    num_d  = num_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = req_i.rem_init;
      num_d  = req_i.num_init;
      dvs_d  = req_i.divisor;
      quo_d  = '0;
      cnt_d  = req_i.last;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[DIV_W-2:0], 1'b0};
      if (!trial[DIV_W+1]) begin
        rem_d = trial[DIV_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DIV_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    cnt_q <= cnt_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

`default_nettype wire

// ===== src/takeoff_sequencer_with_ramp_core.sv =====
// ----------------------------------------------------------------------------
// Takeoff sequencer with velocity ramp
// Five-phase takeoff sequencer producing an upward velocity limit.
// ----------------------------------------------------------------------------
// Outside rampup a tick goes from ST_PHASE straight to ST_OUT. In rampup it
// passes ST_STEP, then as needed the serial division of dt by the ramp time
// (ST_DIV), the serial multiplication of the blend (ST_MUL) and ST_FIN, then
// waits in ST_OUT for the output. One tick is in work at a time; the next
// is taken once the result is registered and the core is idle. A gain write
// holds the input off while start_vz is recomputed. Reset restores defaults.
`default_nettype none

module takeoff_sequencer_with_ramp_core import tosr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  tosr_in_if.sink               in_i,
  tosr_out_if.source            out_o
);

  logic [15:0] gain_q;
  logic [23:0] ramp_q;
  logic [23:0] spool_q;
  logic        gain_wr;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic [16:0]             prog_q, prog_d;
  logic [31:0]             since_q, since_d;
  logic                    seen_q, seen_d;
  logic                    sdone_q, sdone_d;
  logic signed [VZ_W-1:0]  start_vz_q, start_vz_d;
  logic                    gpend_q, gpend_d;
  logic                    out_valid_q, out_valid_d;

  logic signed [22:0]      res_q, res_d;
  logic signed [21:0]      mcand_q, mcand_d;
  logic [15:0]             mplier_q, mplier_d;
  logic signed [37:0]      acc_q, acc_d;
  logic [3:0]              mcnt_q, mcnt_d;
  logic signed [VZ_W-1:0]  out_vz_q;
  phase_e                  out_phase_q;
  logic                    out_load;

  logic                    armed_q, landed_q, want_q, skip_q;
  logic [31:0]             now_q;
  logic [19:0]             dt_q;
  logic signed [15:0]      desired_q;

  logic                    in_fire;
  div_req_t                div_req;
  div_rsp_t                div_rsp;

  logic                    seen_n, sdone_n, ramp_reset;
  logic [31:0]             since_n, elapsed;
  phase_e                  p1, p2, p3, p4, p5, phase_nx;
  logic [15:0]             gain_eff;
  logic [17:0]             prog_sum;
  logic signed [21:0]      vz_diff;
  logic signed [37:0]      acc_adj;

  assign gain_wr  = cfg_we_i && (cfg_idx_i == CFG_GAIN);
  assign in_i.ready = (state_q == ST_IDLE) && !gpend_q && !gain_wr;
  assign in_fire  = in_i.valid && in_i.ready;
  assign gain_eff = (gain_q < GAIN_FLOOR) ? GAIN_FLOOR : gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= GAIN_RESET;
      ramp_q  <= RAMP_RESET;
      spool_q <= SPOOL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GAIN:  gain_q  <= cfg_wdata_i[15:0];
        CFG_RAMP:  ramp_q  <= cfg_wdata_i;
        CFG_SPOOL: spool_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      armed_q   <= in_i.armed;
      landed_q  <= in_i.landed;
      want_q    <= in_i.takeoff_req;
      skip_q    <= in_i.direct_flight;
      now_q     <= in_i.now_us;
      dt_q      <= in_i.dt_us;
      desired_q <= in_i.desired_vz_mm_s;
    end
  end

  // Arming hysteresis and the fall-through phase sequence.
  always_comb begin
    seen_n  = seen_q;
    since_n = since_q;
    sdone_n = sdone_q;
    if (armed_q != sdone_q) begin
      if (armed_q != seen_q) begin
        seen_n  = armed_q;
        since_n = now_q;
      end
    end else begin
      seen_n = sdone_q;
    end
    elapsed = now_q - since_n;
    if (seen_n != sdone_q) begin
      if (sdone_q) begin
        sdone_n = 1'b0;
      end else if (elapsed >= {8'd0, spool_q}) begin
        sdone_n = 1'b1;
      end
    end

    p1 = (phase_q == PH_DISARMED && armed_q) ? PH_SPOOLUP : phase_q;
    p2 = (p1 == PH_SPOOLUP && sdone_n) ? PH_READY : p1;
    ramp_reset = (p2 == PH_READY) && (phase_q <= PH_READY) && want_q;
    p3 = ramp_reset ? PH_RAMPUP : p2;
    p4 = (p3 == PH_RAMPUP && !ramp_reset && prog_q[16]) ? PH_FLIGHT : p3;
    p5 = (p4 == PH_FLIGHT && phase_q <= PH_FLIGHT && landed_q) ? PH_READY : p4;
    if (!armed_q) begin
      phase_nx = PH_DISARMED;
    end else if (skip_q) begin
      phase_nx = PH_FLIGHT;
    end else begin
      phase_nx = p5;
    end
  end

  assign vz_diff  = 22'(desired_q) - 22'(start_vz_q);
  assign prog_sum = {1'b0, prog_q} + {2'b00, div_rsp.quo[15:0]};
  assign acc_adj  = acc_q + (acc_q[37] ? 38'sd65535 : 38'sd0);

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    prog_d      = prog_q;
    seen_d      = seen_q;
    since_d     = since_q;
    sdone_d     = sdone_q;
    start_vz_d  = start_vz_q;
    gpend_d     = gpend_q | gain_wr;
    res_d       = res_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    acc_d       = acc_q;
    mcnt_d      = mcnt_q;
    out_load    = 1'b0;
    div_req     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (gpend_q) begin
          div_req.start    = 1'b1;
          div_req.rem_init = '0;
          div_req.num_init = GRAV_UM_S2;
          div_req.divisor  = {8'd0, gain_eff};
          div_req.last     = 5'(DIV_W - 1);
          gpend_d          = gain_wr;
          state_d          = ST_GDIV;
        end else if (in_fire) begin
          state_d = ST_PHASE;
        end
      end
      ST_GDIV: begin
        if (div_rsp.done) begin
          start_vz_d = -$signed({1'b0, div_rsp.quo[19:0]});
          state_d    = ST_IDLE;
        end
      end
      ST_PHASE: begin
        seen_d  = seen_n;
        since_d = since_n;
        sdone_d = sdone_n;
        phase_d = phase_nx;
        if (ramp_reset) begin
          prog_d = '0;
        end
        if (phase_nx == PH_RAMPUP) begin
          state_d = ST_STEP;
        end else begin
          res_d   = (phase_nx < PH_RAMPUP) ? 23'(start_vz_q) : 23'(desired_q);
          state_d = ST_OUT;
        end
      end
      ST_STEP: begin
        if (ramp_q > {4'd0, dt_q}) begin
          div_req.start    = 1'b1;
          div_req.rem_init = {4'd0, dt_q};
          div_req.num_init = '0;
          div_req.divisor  = ramp_q;
          div_req.last     = 5'd15;
          state_d          = ST_DIV;
        end else begin
          prog_d  = Q16_ONE;
          res_d   = 23'(desired_q);
          state_d = ST_OUT;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          if (prog_sum >= {1'b0, Q16_ONE}) begin
            prog_d  = Q16_ONE;
            res_d   = 23'(desired_q);
            state_d = ST_OUT;
          end else begin
            prog_d   = prog_sum[16:0];
            mplier_d = prog_sum[15:0];
            mcand_d  = vz_diff;
            acc_d    = '0;
            mcnt_d   = 4'd15;
            state_d  = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        acc_d    = (acc_q <<< 1) + (mplier_q[15] ? 38'(mcand_q) : 38'sd0);
        mplier_d = {mplier_q[14:0], 1'b0};
        if (mcnt_q == '0) begin
          state_d = ST_FIN;
        end else begin
          mcnt_d = mcnt_q - 4'd1;
        end
      end
      ST_FIN: begin
        res_d   = 23'(start_vz_q) + 23'($signed(acc_adj[37:16]));
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_DISARMED;
      prog_q      <= '0;
      since_q     <= '0;
      seen_q      <= 1'b0;
      sdone_q     <= 1'b0;
      start_vz_q  <= START_VZ_RESET;
      gpend_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      prog_q      <= prog_d;
      since_q     <= since_d;
      seen_q      <= seen_d;
      sdone_q     <= sdone_d;
      start_vz_q  <= start_vz_d;
      gpend_q     <= gpend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    acc_q    <= acc_d;
    mcnt_q   <= mcnt_d;
    if (out_load) begin
      out_vz_q    <= sat_vz(res_q);
      out_phase_q <= phase_q;
    end
  end

  tosr_sdiv u_sdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_o.valid         = out_valid_q;
  assign out_o.vz_limit_mm_s = out_vz_q;
  assign out_o.phase         = out_phase_q;

  a_accept_starts_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_PHASE)
    else $error("Accepted tick did not enter the sequencer step.");

  a_prog_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prog_q[16] |-> prog_q[15:0] == 16'd0)
    else $error("Ramp progress exceeds one.");

  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV || state_q == ST_GDIV))
    else $error("Divider finished outside a division state.");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && state_q != ST_OUT)
    else $error("Result was not presented after loading.");

  a_no_accept_during_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_GDIV |-> !in_i.ready)
    else $error("Tick accepted while the start velocity is being recomputed.");

endmodule

`default_nettype wire

// ===== sim/takeoff_sequencer_with_ramp_core_tb.sv =====
// ----------------------------------------------------------------------------
// Takeoff sequencer with velocity ramp testbench
// Drives control ticks through the sequencer under several register settings
// and checks every velocity limit and phase against a cycle-free prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module takeoff_sequencer_with_ramp_core_tb import tosr_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 48;
  localparam int CYCLE_LIMIT   = 600000;

  typedef struct packed {
    logic               armed;
    logic               landed;
    logic               takeoff_req;
    logic               direct_flight;
    logic [31:0]        now_us;
    logic [19:0]        dt_us;
    logic signed [15:0] desired_vz_mm_s;
  } tick_t;

  typedef struct packed {
    logic signed [VZ_W-1:0] vz;
    phase_e                 phase;
  } limit_t;

  class climb_scoreboard;
    logic [15:0] gain_milli;
    logic [23:0] ramp_us;
    logic [23:0] spool_us;
    phase_e      phase_q;
    logic [16:0] progress_q16;
    logic [31:0] armed_since_us;
    bit          armed_seen;
    bit          spool_done;
    int          start_vz;
    limit_t      limits_due[$];
    int          mismatches;

    function new();
      gain_milli     = GAIN_RESET;
      ramp_us        = RAMP_RESET;
      spool_us       = SPOOL_RESET;
      phase_q        = PH_DISARMED;
      progress_q16   = '0;
      armed_since_us = '0;
      armed_seen     = 1'b0;
      spool_done     = 1'b0;
      mismatches     = 0;
      update_start_vz();
    endfunction

    function void update_start_vz();
      int unsigned g;
      g = (gain_milli < GAIN_FLOOR) ? GAIN_FLOOR : gain_milli;
      start_vz = -int'(GRAV_UM_S2 / g);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GAIN: begin
          gain_milli = data[15:0];
          update_start_vz();
        end
        CFG_RAMP:  ramp_us = data;
        CFG_SPOOL: spool_us = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return limits_due.size();
    endfunction

    function void note_tick(tick_t t);
      phase_e      nxt;
      logic [31:0] elapsed;
      longint      lim;
      longint      diff;
      longint      stp;
      longint      sum;
      limit_t      res;

      // Arming hysteresis: delayed rise, immediate fall.
      if (t.armed != spool_done) begin
        if (t.armed != armed_seen) begin
          armed_seen     = t.armed;
          armed_since_us = t.now_us;
        end
      end else begin
        armed_seen = spool_done;
      end
      if (armed_seen != spool_done) begin
        elapsed = t.now_us - armed_since_us;
        if (spool_done) begin
          spool_done = 1'b0;
        end else if (elapsed >= spool_us) begin
          spool_done = 1'b1;
        end
      end

      nxt = phase_q;
      if (nxt == PH_DISARMED && t.armed) nxt = PH_SPOOLUP;
      if (nxt == PH_SPOOLUP && spool_done) nxt = PH_READY;
      if (nxt == PH_READY && t.takeoff_req) begin
        nxt          = PH_RAMPUP;
        progress_q16 = '0;
      end
      if (nxt == PH_RAMPUP && progress_q16 >= Q16_ONE) nxt = PH_FLIGHT;
      if (nxt == PH_FLIGHT && t.landed) nxt = PH_READY;
      if (t.armed && t.direct_flight) nxt = PH_FLIGHT;
      if (!t.armed) nxt = PH_DISARMED;
      phase_q = nxt;

      lim = t.desired_vz_mm_s;
      if (phase_q < PH_RAMPUP) lim = start_vz;
      if (phase_q == PH_RAMPUP) begin
        if (ramp_us > t.dt_us) begin
          stp          = (longint'(t.dt_us) << 16) / longint'(ramp_us);
          sum          = longint'(progress_q16) + stp;
          progress_q16 = (sum > 65536) ? Q16_ONE : 17'(sum);
        end else begin
          progress_q16 = Q16_ONE;
        end
        if (progress_q16 < Q16_ONE) begin
          diff = longint'(t.desired_vz_mm_s) - longint'(start_vz);
          lim  = longint'(start_vz) + (longint'(progress_q16) * diff) / 65536;
        end
      end
      if (lim > longint'(VZ_MAX)) lim = longint'(VZ_MAX);
      if (lim < -longint'(VZ_MAX)) lim = -longint'(VZ_MAX);

      res.vz    = lim[VZ_W-1:0];
      res.phase = phase_q;
      limits_due.push_back(res);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_limit(logic signed [VZ_W-1:0] vz, logic [2:0] ph);
      limit_t want;
      if (limits_due.size() == 0) begin
        report($sformatf("unexpected transfer vz=%0d phase=%0d", vz, ph));
      end else begin
        want = limits_due.pop_front();
        if (vz !== want.vz) begin
          report($sformatf("vz_limit_mm_s got %0d, predicted %0d", vz, want.vz));
        end
        if (ph !== want.phase) begin
          report($sformatf("phase got %0d, predicted %0d", ph, want.phase));
        end
      end
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  tosr_in_if  in_if ();
  tosr_out_if out_if ();

  takeoff_sequencer_with_ramp_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  climb_scoreboard sb;
  bit              calm;
  int              hold_left;
  int              dt_cap;
  int              cycles;
  logic [31:0]     clock_us;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= calm || ($urandom_range(99) >= 10);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        sb.check_limit(out_if.vz_limit_mm_s, out_if.phase);
      end
    end
  end

  function automatic tick_t mk_tick(bit a, bit l, bit w, bit s, logic [31:0] now_us,
                                    logic [19:0] dt_us, int desired);
    tick_t t;
    t.armed           = a;
    t.landed          = l;
    t.takeoff_req     = w;
    t.direct_flight   = s;
    t.now_us          = now_us;
    t.dt_us           = dt_us;
    t.desired_vz_mm_s = 16'(desired);
    return t;
  endfunction

  function automatic tick_t random_tick(bit wild);
    tick_t t;
    int    desired;
    if (wild) begin
      t.armed         = 1'($urandom_range(1));
      t.landed        = 1'($urandom_range(1));
      t.takeoff_req   = 1'($urandom_range(1));
      t.direct_flight = 1'($urandom_range(1));
    end else begin
      t.armed         = ($urandom_range(99) >= 3);
      t.landed        = ($urandom_range(99) < 6);
      t.takeoff_req   = ($urandom_range(99) < 35);
      t.direct_flight = ($urandom_range(99) < 4);
    end
    if (wild || $urandom_range(99) < 10) begin
      t.dt_us = 20'($urandom_range(1000000));
    end else begin
      t.dt_us = 20'($urandom_range(dt_cap));
    end
    if (wild || $urandom_range(99) < 3) begin
      clock_us = $urandom;
    end else begin
      clock_us = clock_us + t.dt_us;
    end
    t.now_us          = clock_us;
    desired           = int'($urandom_range(40000)) - 20000;
    t.desired_vz_mm_s = 16'(desired);
    return t;
  endfunction

  task automatic send_tick(input tick_t t);
    if (!calm && $urandom_range(99) < 10) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_if.valid           <= 1'b1;
    in_if.armed           <= t.armed;
    in_if.landed          <= t.landed;
    in_if.takeoff_req     <= t.takeoff_req;
    in_if.direct_flight   <= t.direct_flight;
    in_if.now_us          <= t.now_us;
    in_if.dt_us           <= t.dt_us;
    in_if.desired_vz_mm_s <= t.desired_vz_mm_s;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_tick(t);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic configure(input int unsigned gain, input int unsigned ramp,
                           input int unsigned spool);
    int unsigned longest;
    write_reg(CFG_GAIN, CFG_DATA_W'(gain));
    write_reg(CFG_RAMP, CFG_DATA_W'(ramp));
    write_reg(CFG_SPOOL, CFG_DATA_W'(spool));
    longest = (ramp > spool) ? ramp : spool;
    dt_cap  = int'(longest / 6);
    if (dt_cap < 2000) dt_cap = 2000;
    if (dt_cap > 1000000) dt_cap = 1000000;
  endtask

  // Mostly flights from arming to climb-out with random content, with short
  // bursts of unstructured ticks in between.
  task automatic run_flights(input int n_ticks);
    int sent;
    int len;
    bit wild;
    sent = 0;
    while (sent < n_ticks) begin
      wild = ($urandom_range(99) < 15);
      len  = wild ? $urandom_range(1, 4) : $urandom_range(8, 50);
      repeat (len) send_tick(random_tick(wild));
      sent += len;
    end
  endtask

  initial begin
    sb                    = new();
    calm                  = 1'b0;
    hold_left             = 0;
    dt_cap                = 500000;
    clock_us              = '0;
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = CFG_GAIN;
    cfg_wdata_i           = '0;
    in_if.valid           = 1'b0;
    in_if.armed           = 1'b0;
    in_if.landed          = 1'b0;
    in_if.takeoff_req     = 1'b0;
    in_if.direct_flight   = 1'b0;
    in_if.now_us          = '0;
    in_if.dt_us           = '0;
    in_if.desired_vz_mm_s = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_tick(mk_tick(0, 0, 0, 0, 32'h0000_0000, 20'd0, 0));
    send_tick(mk_tick(1, 0, 0, 0, 32'hFFFF_0000, 20'd0, -20000));
    send_tick(mk_tick(1, 0, 1, 0, 32'hFFFF_FFFF, 20'd1000000, 20000));
    send_tick(mk_tick(1, 0, 0, 0, 32'd2097152, 20'd0, 0));
    send_tick(mk_tick(1, 0, 1, 0, 32'd2097152, 20'd0, 20000));
    send_tick(mk_tick(1, 0, 0, 0, 32'd3097152, 20'd1000000, 20000));
    send_tick(mk_tick(1, 0, 0, 0, 32'd4097152, 20'd1000000, -20000));
    send_tick(mk_tick(1, 1, 0, 0, 32'd5097152, 20'd1000000, 20000));
    send_tick(mk_tick(1, 0, 0, 0, 32'd6097152, 20'd1000000, 20000));
    send_tick(mk_tick(1, 0, 0, 0, 32'd6107152, 20'd10000, 1234));
    send_tick(mk_tick(1, 1, 0, 0, 32'd6117152, 20'd10000, -1234));
    send_tick(mk_tick(1, 0, 1, 1, 32'd6127152, 20'd10000, 0));
    send_tick(mk_tick(0, 0, 0, 1, 32'd6137152, 20'd10000, 20000));
    send_tick(mk_tick(1, 0, 0, 1, 32'd6147152, 20'd10000, -20000));
    send_tick(mk_tick(0, 1, 1, 0, 32'd6157152, 20'd0, 0));
    send_tick(mk_tick(1, 1, 1, 1, 32'hFFFF_FFFF, 20'd1000000, 20000));
    run_flights(300);

    configure(0, 0, 0);
    run_flights(250);

    configure(65535, 24'hFFFFFF, 24'hFFFFFF);
    run_flights(300);

    calm = 1'b1;
    configure(10, 1, 1);
    run_flights(250);
    calm = 1'b0;

    configure($urandom_range(100, 20000), $urandom_range(20000, 500000),
              $urandom_range(10000, 300000));
    hold_left = 400;
    run_flights(450);

    drain();
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
